// ===== design/ddgp_pkg.sv =====
// ----------------------------------------------------------------------------
// ddgp_pkg
// Shared constants for the goto-point steering pipeline: field widths,
// CORDIC arctangent table, fixed-point formats and inner-wheel factors.
// ----------------------------------------------------------------------------
package ddgp_pkg;

    localparam int DEF_COORD_BITS = 16;
    localparam int DEF_ANGLE_BITS = 16;

    localparam int CORDIC_STEPS = 28;
    localparam int FRAC_BITS    = 32;

    // arctan(2^-i) in 2^32 units per turn
    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005
    };

    localparam int SPEED_BITS = 16;
    localparam int DECAY_BITS = 16;
    localparam int QUOT_BITS  = 20;
    localparam int RATIO_BITS = 21;
    localparam int FACT_BITS  = 33;
    localparam int TENTH_BITS = 4;
    localparam int SQUARINGS  = 16;

    localparam logic [RATIO_BITS-1:0] RATIO_CLAMP = 21'h10_0000;
    localparam logic [FACT_BITS-1:0]  ONE_Q32     = 33'h1_0000_0000;

    // inner wheel factor in tenths of the outer wheel
    localparam logic [TENTH_BITS-1:0] INNER_SPIN     = 4'd0;
    localparam logic [TENTH_BITS-1:0] INNER_SHARP    = 4'd3;
    localparam logic [TENTH_BITS-1:0] INNER_MEDIUM   = 4'd6;
    localparam logic [TENTH_BITS-1:0] INNER_GENTLE   = 4'd7;
    localparam logic [TENTH_BITS-1:0] INNER_TRIM     = 4'd8;
    localparam logic [TENTH_BITS-1:0] INNER_STRAIGHT = 4'd10;

    // configuration register indexes
    localparam logic REG_MAX_SPEED      = 1'b0;
    localparam logic REG_DECAY_DISTANCE = 1'b1;

endpackage

// ===== design/diff_drive_goto_point_steering.sv =====
// ----------------------------------------------------------------------------
// diff_drive_goto_point_steering
// Wheel speeds for a differential-drive robot heading for a target point.
// ----------------------------------------------------------------------------
// A request passes the square root (one root bit a stage) and the divider
//   (one quotient bit a stage), then sixteen squarings of two stages each.
// Throughput: one request per cycle; busy never rises, done strobes one cycle.
// Reset clears every valid bit and loads max_speed 7680 and decay_distance 20.
// ----------------------------------------------------------------------------
module diff_drive_goto_point_steering #(
    parameter int COORD_BITS = ddgp_pkg::DEF_COORD_BITS,
    parameter int ANGLE_BITS = ddgp_pkg::DEF_ANGLE_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [COORD_BITS-1:0]      target_x,
    input  logic signed [COORD_BITS-1:0]      target_y,
    input  logic signed [COORD_BITS-1:0]      robot_x,
    input  logic signed [COORD_BITS-1:0]      robot_y,
    input  logic signed [ANGLE_BITS-1:0]      robot_heading,
    input  logic                              wr_en,
    input  logic                              wr_index,
    input  logic [ddgp_pkg::SPEED_BITS-1:0]   wr_data,
    output logic                              done,
    output logic [ddgp_pkg::SPEED_BITS-1:0]   left_speed,
    output logic [ddgp_pkg::SPEED_BITS-1:0]   right_speed
);

    localparam int SB  = ddgp_pkg::SPEED_BITS;
    localparam int TB  = ddgp_pkg::TENTH_BITS;
    localparam int FB  = ddgp_pkg::FACT_BITS;

    // stage counts of the sub-pipelines; the angle path is padded to meet
    // the distance path at the speed multiplier
    localparam int LAT_CORDIC = ddgp_pkg::CORDIC_STEPS + 2;
    localparam int LAT_DIST   = COORD_BITS + 32;
    localparam int LAT_EXP    = 2 + 2 * ddgp_pkg::SQUARINGS + 1;
    localparam int DLY        = LAT_DIST + LAT_EXP - LAT_CORDIC - 1;
    localparam int LATENCY    = 1 + LAT_DIST + LAT_EXP + 4;

    localparam int SW = ANGLE_BITS + 9;
    localparam logic [SW-1:0] LIM_100 = SW'(100) << ANGLE_BITS;
    localparam logic [SW-1:0] LIM_90  = SW'(90)  << ANGLE_BITS;
    localparam logic [SW-1:0] LIM_50  = SW'(50)  << ANGLE_BITS;
    localparam logic [SW-1:0] LIM_20  = SW'(20)  << ANGLE_BITS;
    localparam logic [SW-1:0] LIM_1   = SW'(1)   << ANGLE_BITS;

    localparam int PW = SB + FB;
    localparam int HW = PW + TB + 1;
    localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;

    // ---------------------------------------------------------------- config
    logic [SB-1:0] max_speed_reg;
    logic [SB-1:0] decay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg <= 16'd7680;
            decay_reg     <= 16'd20;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                ddgp_pkg::REG_MAX_SPEED:      max_speed_reg <= wr_data;
                ddgp_pkg::REG_DECAY_DISTANCE: decay_reg     <= wr_data;
                default:                      max_speed_reg <= max_speed_reg;
            endcase
        end
    end

    // ---------------------------------------------------- offset to target
    // Register the offsets once; both the angle and distance paths start here.
    logic                       vld0_reg;
    logic signed [COORD_BITS:0] dx_reg;
    logic signed [COORD_BITS:0] dy_reg;
    logic [ANGLE_BITS-1:0]      hd0_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld0_reg <= 1'b0;
        else
            vld0_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= (COORD_BITS+1)'(target_x) - (COORD_BITS+1)'(robot_x);
        dy_reg  <= (COORD_BITS+1)'(target_y) - (COORD_BITS+1)'(robot_y);
        hd0_reg <= robot_heading;
    end

    // ------------------------------------------------------------ angle path
    logic                  cor_vld;
    logic [ANGLE_BITS-1:0] bearing;
    logic [ANGLE_BITS-1:0] cor_heading;

    ddgp_cordic #(
        .COORD_BITS (COORD_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cordic (
        .clk         (clk),
        .rst_n       (rst_n),
        .vld         (vld0_reg),
        .dx          (dx_reg),
        .dy          (dy_reg),
        .heading     (hd0_reg),
        .res_vld     (cor_vld),
        .bearing     (bearing),
        .res_heading (cor_heading)
    );

    // Heading error wraps to a half turn; an exact half turn counts as
    // negative so the left wheel stays inner.
    logic [ANGLE_BITS-1:0] err;
    logic [ANGLE_BITS-1:0] mag;
    logic [SW-1:0]         scaled;
    logic [TB-1:0]         tenths;

    assign err    = bearing - cor_heading;
    assign mag    = err[ANGLE_BITS-1] ? ANGLE_BITS'(-err) : err;
    assign scaled = SW'(mag) * SW'(360);

    always_comb
    begin
        if (scaled > LIM_100)
            tenths = ddgp_pkg::INNER_SPIN;
        else if (scaled > LIM_90)
            tenths = ddgp_pkg::INNER_SHARP;
        else if (scaled > LIM_50)
            tenths = ddgp_pkg::INNER_MEDIUM;
        else if (scaled > LIM_20)
            tenths = ddgp_pkg::INNER_GENTLE;
        else if (scaled >= LIM_1)
            tenths = ddgp_pkg::INNER_TRIM;
        else
            tenths = ddgp_pkg::INNER_STRAIGHT;
    end

    logic          band_vld_reg;
    logic          band_pos_reg;
    logic [TB-1:0] band_ten_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            band_vld_reg <= 1'b0;
        else
            band_vld_reg <= cor_vld;
    end

    always_ff @(posedge clk)
    begin
        band_pos_reg <= (err != '0) && !err[ANGLE_BITS-1];
        band_ten_reg <= tenths;
    end

    // Hold the band result until the approach factor catches up.
    logic          dly_vld_reg [0:DLY-1];
    logic          dly_pos_reg [0:DLY-1];
    logic [TB-1:0] dly_ten_reg [0:DLY-1];

    for (genvar k = 0; k < DLY; k++)
    begin : g_dly
        logic          vld_src;
        logic          pos_src;
        logic [TB-1:0] ten_src;
        if (k == 0)
        begin : g_head
            assign vld_src = band_vld_reg;
            assign pos_src = band_pos_reg;
            assign ten_src = band_ten_reg;
        end
        else
        begin : g_tail
            assign vld_src = dly_vld_reg[k-1];
            assign pos_src = dly_pos_reg[k-1];
            assign ten_src = dly_ten_reg[k-1];
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dly_vld_reg[k] <= 1'b0;
            else
                dly_vld_reg[k] <= vld_src;
        end
        always_ff @(posedge clk)
        begin
            dly_pos_reg[k] <= pos_src;
            dly_ten_reg[k] <= ten_src;
        end
    end

    // --------------------------------------------------------- distance path
    logic                            dist_vld;
    logic [ddgp_pkg::RATIO_BITS-1:0] ratio;
    logic                            exp_vld;
    logic [FB-1:0]                   factor;

    ddgp_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld     (vld0_reg),
        .dx      (dx_reg),
        .dy      (dy_reg),
        .decay   (decay_reg),
        .res_vld (dist_vld),
        .ratio   (ratio)
    );

    ddgp_exp u_exp (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld     (dist_vld),
        .ratio   (ratio),
        .res_vld (exp_vld),
        .factor  (factor)
    );

    // ---------------------------------------------------------- wheel speeds
    // Scale by max_speed, then the inner wheel by tenths and a divide by ten
    // through a reciprocal multiply.
    logic [3:0]    sv_reg;
    logic [PW-1:0] p_reg;
    logic          pos1_reg;
    logic [TB-1:0] ten1_reg;
    logic [PW-1:0] p_round;
    logic [HW-1:0] pt;
    logic [SB:0]   outer2_reg;
    logic [31:0]   h2_reg;
    logic          pos2_reg;
    logic [SB:0]   outer3_reg;
    logic [63:0]   hq3_reg;
    logic          pos3_reg;
    logic [28:0]   inner_full;
    logic [SB-1:0] inner_sat;
    logic [SB-1:0] outer_sat;
    logic          done_reg;
    logic [SB-1:0] left_reg;
    logic [SB-1:0] right_reg;

    assign p_round = p_reg + (PW'(1) << 31);
    assign pt      = HW'(p_reg) * HW'(ten1_reg) + (HW'(5) << 32);

    always_ff @(posedge clk)
    begin
        p_reg      <= PW'(max_speed_reg) * PW'(factor);
        pos1_reg   <= dly_pos_reg[DLY-1];
        ten1_reg   <= dly_ten_reg[DLY-1];
        outer2_reg <= p_round[PW-1:32];
        h2_reg     <= 32'(pt[HW-1:32]);
        pos2_reg   <= pos1_reg;
        outer3_reg <= outer2_reg;
        hq3_reg    <= 64'(h2_reg) * 64'(RECIP_10);
        pos3_reg   <= pos2_reg;
    end

    assign inner_full = hq3_reg[63:35];
    assign inner_sat  = (inner_full > 29'(16'hFFFF)) ? 16'hFFFF : inner_full[SB-1:0];
    assign outer_sat  = outer3_reg[SB] ? 16'hFFFF : outer3_reg[SB-1:0];

    always_ff @(posedge clk)
    begin
        left_reg  <= pos3_reg ? outer_sat : inner_sat;
        right_reg <= pos3_reg ? inner_sat : outer_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            sv_reg   <= {sv_reg[2:0], exp_vld};
            done_reg <= sv_reg[2];
        end
    end

    assign done        = done_reg;
    assign left_speed  = left_reg;
    assign right_speed = right_reg;

`ifndef SYNTHESIS
    // angle and distance paths must meet on the same word
    a_paths_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        dly_vld_reg[DLY-1] == exp_vld)
        else $error("angle and distance paths out of step");

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("request did not complete at the fixed latency");

    a_on_target_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (target_x == robot_x) && (target_y == robot_y))
        |-> ##LATENCY ((left_speed == '0) && (right_speed == '0)))
        else $error("robot on target but wheels not stopped");
`endif

endmodule

// ===== design/ddgp_cordic.sv =====
// ----------------------------------------------------------------------------
// ddgp_cordic
// Pipelined CORDIC vectoring: bearing of (dx,dy), one rotation per stage,
// rounded to the heading angle width.
// ----------------------------------------------------------------------------
module ddgp_cordic #(
    parameter int COORD_BITS = ddgp_pkg::DEF_COORD_BITS,
    parameter int ANGLE_BITS = ddgp_pkg::DEF_ANGLE_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         vld,
    input  logic signed [COORD_BITS:0]   dx,
    input  logic signed [COORD_BITS:0]   dy,
    input  logic [ANGLE_BITS-1:0]        heading,
    output logic                         res_vld,
    output logic [ANGLE_BITS-1:0]        bearing,
    output logic [ANGLE_BITS-1:0]        res_heading
);

    localparam int N = ddgp_pkg::CORDIC_STEPS;
    localparam int W = COORD_BITS + 3 + ddgp_pkg::FRAC_BITS;
    localparam logic [31:0] HALF_LSB = 32'(1) << (31 - ANGLE_BITS);

    logic signed [W-1:0]   px_reg [0:N];
    logic signed [W-1:0]   py_reg [0:N];
    logic [31:0]           z_reg  [0:N];
    logic                  zero_reg [0:N];
    logic [ANGLE_BITS-1:0] hd_reg [0:N];
    logic [N:0]            vld_reg;
    logic                  res_vld_reg;
    logic [ANGLE_BITS-1:0] bearing_reg;
    logic [ANGLE_BITS-1:0] res_heading_reg;

    logic signed [COORD_BITS:0] dxn;
    logic signed [COORD_BITS:0] dyn;
    logic [31:0]                z_round;

    // fold the left half plane onto the right one
    assign dxn = dx[COORD_BITS] ? -dx : dx;
    assign dyn = dx[COORD_BITS] ? -dy : dy;

    always_ff @(posedge clk)
    begin
        px_reg[0]   <= {{2{dxn[COORD_BITS]}}, dxn, 32'b0};
        py_reg[0]   <= {{2{dyn[COORD_BITS]}}, dyn, 32'b0};
        z_reg[0]    <= dx[COORD_BITS] ? 32'h8000_0000 : 32'h0;
        zero_reg[0] <= (dx == '0) && (dy == '0);
        hd_reg[0]   <= heading;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (!py_reg[i][W-1])
            begin
                px_reg[i+1] <= px_reg[i] + (py_reg[i] >>> i);
                py_reg[i+1] <= py_reg[i] - (px_reg[i] >>> i);
                z_reg[i+1]  <= z_reg[i] + ddgp_pkg::ATAN_TURNS[i];
            end
            else
            begin
                px_reg[i+1] <= px_reg[i] - (py_reg[i] >>> i);
                py_reg[i+1] <= py_reg[i] + (px_reg[i] >>> i);
                z_reg[i+1]  <= z_reg[i] - ddgp_pkg::ATAN_TURNS[i];
            end
            zero_reg[i+1] <= zero_reg[i];
            hd_reg[i+1]   <= hd_reg[i];
        end
    end

    assign z_round = z_reg[N] + HALF_LSB;

    always_ff @(posedge clk)
    begin
        bearing_reg     <= zero_reg[N] ? '0 : z_round[31 -: ANGLE_BITS];
        res_heading_reg <= hd_reg[N];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg     <= {vld_reg[N-1:0], vld};
            res_vld_reg <= vld_reg[N];
        end
    end

    assign res_vld     = res_vld_reg;
    assign bearing     = bearing_reg;
    assign res_heading = res_heading_reg;

endmodule

// ===== design/ddgp_dist.sv =====
// ----------------------------------------------------------------------------
// ddgp_dist
// Distance over decay ratio: squares, far-target test, bit-per-stage
// square root and bit-per-stage restoring divide, clamped to 16.0 in Q.16.
// ----------------------------------------------------------------------------
module ddgp_dist #(
    parameter int COORD_BITS = ddgp_pkg::DEF_COORD_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 vld,
    input  logic signed [COORD_BITS:0]           dx,
    input  logic signed [COORD_BITS:0]           dy,
    input  logic [ddgp_pkg::DECAY_BITS-1:0]      decay,
    output logic                                 res_vld,
    output logic [ddgp_pkg::RATIO_BITS-1:0]      ratio
);

    localparam int DB   = ddgp_pkg::DECAY_BITS;
    localparam int QB   = ddgp_pkg::QUOT_BITS;
    localparam int NSQ  = COORD_BITS + 9;
    localparam int VB   = 2 * NSQ;
    localparam int SQB  = 2 * COORD_BITS;
    localparam int LB   = 2 * (DB + 4);
    localparam int CMPW = (SQB + 1 > LB) ? SQB + 1 : LB;
    localparam int DIVW = DB + QB;
    localparam int NST  = 2 + NSQ + QB;

    logic signed [2*COORD_BITS+1:0] sqx_full;
    logic signed [2*COORD_BITS+1:0] sqy_full;
    logic [DB-1:0]                  dec;
    logic [DB+3:0]                  lim;

    logic [SQB-1:0]  sqx_reg;
    logic [SQB-1:0]  sqy_reg;
    logic [LB-1:0]   lim2_reg;
    logic [DB-1:0]   dec1_reg;
    logic [SQB:0]    d2;

    logic [VB-1:0]   v_reg   [0:NSQ];
    logic [VB-1:0]   r_reg   [0:NSQ];
    logic            sat_reg [0:NSQ+QB];
    logic [DB-1:0]   dec_reg [0:NSQ+QB];
    logic [DIVW-1:0] rem_reg [1:QB];
    logic [QB-1:0]   q_reg   [1:QB];
    logic [NST-1:0]  vld_reg;
    logic            res_vld_reg;
    logic [ddgp_pkg::RATIO_BITS-1:0] ratio_reg;
    logic [ddgp_pkg::RATIO_BITS-1:0] q_ext;

    assign sqx_full = dx * dx;
    assign sqy_full = dy * dy;
    assign dec      = (decay == '0) ? DB'(1) : decay;
    assign lim      = {dec, 4'b0000};

    // squares and the clamp limit
    always_ff @(posedge clk)
    begin
        sqx_reg  <= sqx_full[SQB-1:0];
        sqy_reg  <= sqy_full[SQB-1:0];
        lim2_reg <= LB'(lim) * LB'(lim);
        dec1_reg <= dec;
    end

    assign d2 = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    // far-target test and square root operand in Q.16
    always_ff @(posedge clk)
    begin
        sat_reg[0] <= CMPW'(d2) >= CMPW'(lim2_reg);
        dec_reg[0] <= dec1_reg;
        v_reg[0]   <= {1'b0, d2, 16'b0};
        r_reg[0]   <= '0;
    end

    for (genvar k = 0; k < NSQ; k++)
    begin : g_sqrt
        localparam logic [VB-1:0] BIT = VB'(1) << (VB - 2 - 2 * k);
        logic [VB-1:0] trial;
        assign trial = r_reg[k] + BIT;
        always_ff @(posedge clk)
        begin
            if (v_reg[k] >= trial)
            begin
                v_reg[k+1] <= v_reg[k] - trial;
                r_reg[k+1] <= (r_reg[k] >> 1) + BIT;
            end
            else
            begin
                v_reg[k+1] <= v_reg[k];
                r_reg[k+1] <= r_reg[k] >> 1;
            end
            sat_reg[k+1] <= sat_reg[k];
            dec_reg[k+1] <= dec_reg[k];
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_div
        localparam int JJ = QB - 1 - k;
        logic [DIVW-1:0] rem_in;
        logic [QB-1:0]   q_in;
        logic [DIVW-1:0] dsh;
        if (k == 0)
        begin : g_first
            // the quotient fits whenever the far-target test fails
            assign rem_in = {r_reg[NSQ][DIVW-9:0], 8'b0};
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k];
            assign q_in   = q_reg[k];
        end
        assign dsh = DIVW'(dec_reg[NSQ+k]) << JJ;
        always_ff @(posedge clk)
        begin
            if (rem_in >= dsh)
            begin
                rem_reg[k+1] <= rem_in - dsh;
                q_reg[k+1]   <= q_in | (QB'(1) << JJ);
            end
            else
            begin
                rem_reg[k+1] <= rem_in;
                q_reg[k+1]   <= q_in;
            end
            sat_reg[NSQ+k+1] <= sat_reg[NSQ+k];
            dec_reg[NSQ+k+1] <= dec_reg[NSQ+k];
        end
    end

    assign q_ext = {1'b0, q_reg[QB]};

    always_ff @(posedge clk)
    begin
        if (sat_reg[NSQ+QB] || (q_ext > ddgp_pkg::RATIO_CLAMP))
            ratio_reg <= ddgp_pkg::RATIO_CLAMP;
        else
            ratio_reg <= q_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg     <= {vld_reg[NST-2:0], vld};
            res_vld_reg <= vld_reg[NST-1];
        end
    end

    assign res_vld = res_vld_reg;
    assign ratio   = ratio_reg;

endmodule

// ===== design/ddgp_exp.sv =====
// ----------------------------------------------------------------------------
// ddgp_exp
// Approach factor 1 - exp(-r): second-order seed for exp(-r/65536), then
// sixteen rounded squarings, each a multiply stage and a round stage.
// ----------------------------------------------------------------------------
module ddgp_exp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             vld,
    input  logic [ddgp_pkg::RATIO_BITS-1:0]  ratio,
    output logic                             res_vld,
    output logic [ddgp_pkg::FACT_BITS-1:0]   factor
);

    localparam int RB  = ddgp_pkg::RATIO_BITS;
    localparam int FB  = ddgp_pkg::FACT_BITS;
    localparam int NS  = ddgp_pkg::SQUARINGS;
    localparam int PB  = 2 * FB;
    localparam int NST = 2 + 2 * NS;

    logic [2*RB-1:0] rsq_reg;
    logic [RB-1:0]   r_reg;
    logic            z1_reg;
    logic [2*RB:0]   rsq_round;

    logic [FB-1:0]   e_reg  [0:NS];
    logic            ze_reg [0:NS];
    logic [PB-1:0]   p_reg  [0:NS-1];
    logic            zp_reg [0:NS-1];
    logic [NST-1:0]  vld_reg;
    logic            res_vld_reg;
    logic [FB-1:0]   factor_reg;

    always_ff @(posedge clk)
    begin
        rsq_reg <= (2*RB)'(ratio) * (2*RB)'(ratio);
        r_reg   <= ratio;
        z1_reg  <= (ratio == '0);
    end

    assign rsq_round = {1'b0, rsq_reg} + ((2*RB+1)'(1) << 32);

    always_ff @(posedge clk)
    begin
        e_reg[0]  <= ddgp_pkg::ONE_Q32 - FB'(r_reg) + FB'(rsq_round >> 33);
        ze_reg[0] <= z1_reg;
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_sq
        logic [PB-1:0] p_round;
        assign p_round = p_reg[k] + (PB'(1) << 31);
        always_ff @(posedge clk)
        begin
            p_reg[k]    <= PB'(e_reg[k]) * PB'(e_reg[k]);
            zp_reg[k]   <= ze_reg[k];
            e_reg[k+1]  <= p_round[FB+31:32];
            ze_reg[k+1] <= zp_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        factor_reg <= ze_reg[NS] ? '0 : ddgp_pkg::ONE_Q32 - e_reg[NS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg     <= {vld_reg[NST-2:0], vld};
            res_vld_reg <= vld_reg[NST-1];
        end
    end

    assign res_vld = res_vld_reg;
    assign factor  = factor_reg;

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the goto-point steering block. Requests go in
// through the start/busy handshake; each word on done is checked against a
// predictor of wheel speeds kept in the bench, under several register settings.
// ----------------------------------------------------------------------------
module tb;

    localparam int  LATENCY   = 88;
    localparam int  LIMIT     = 400000;
    localparam int  N_RANDOM  = 330;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] right;
    } speeds_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic signed [15:0] robot_x;
    logic signed [15:0] robot_y;
    logic signed [15:0] robot_heading;
    logic               wr_en;
    logic               wr_index;
    logic [15:0]        wr_data;
    logic               done;
    logic [15:0]        left_speed;
    logic [15:0]        right_speed;

    // bench copy of the two registers
    logic [15:0]        top_speed;
    logic [15:0]        decay_px;

    speeds_t            pending_speeds[$];
    int                 mismatches;
    int                 words_checked;
    int                 requests_sent;
    int                 cycle_count;
    bit                 no_gaps;

    diff_drive_goto_point_steering DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .target_x     (target_x),
        .target_y     (target_y),
        .robot_x      (robot_x),
        .robot_y      (robot_y),
        .robot_heading(robot_heading),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .done         (done),
        .left_speed   (left_speed),
        .right_speed  (right_speed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // integer square root, floor
    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // direction of (dx,dy) in 2^32 units per turn, vectoring CORDIC
    function automatic logic [31:0] bearing_turns(input longint dx, input longint dy);
        longint      px;
        longint      py;
        longint      nx;
        logic [31:0] z;
        z = 32'h0;
        if (dx == 0 && dy == 0)
            return 32'h0;
        if (dx < 0)
        begin
            dx = -dx;
            dy = -dy;
            z  = 32'h8000_0000;
        end
        px = dx <<< 32;
        py = dy <<< 32;
        for (int i = 0; i < ddgp_pkg::CORDIC_STEPS; i++)
        begin
            if (py >= 0)
            begin
                nx = px + (py >>> i);
                py = py - (px >>> i);
                z  = z + ddgp_pkg::ATAN_TURNS[i];
            end
            else
            begin
                nx = px - (py >>> i);
                py = py + (px >>> i);
                z  = z - ddgp_pkg::ATAN_TURNS[i];
            end
            px = nx;
        end
        return z;
    endfunction

    // 1 - exp(-r), r in Q.16, result in Q0.32
    function automatic longint unsigned approach_q32(input longint unsigned r);
        longint unsigned e;
        if (r == 0)
            return 0;
        e = (64'd1 << 32) - r + ((r * r + (64'd1 << 32)) >> 33);
        for (int i = 0; i < ddgp_pkg::SQUARINGS; i++)
            e = (e * e + (64'd1 << 31)) >> 32;
        return (64'd1 << 32) - e;
    endfunction

    function automatic speeds_t wheel_speeds(input logic signed [15:0] tx,
                                             input logic signed [15:0] ty,
                                             input logic signed [15:0] rx,
                                             input logic signed [15:0] ry,
                                             input logic signed [15:0] hd);
        longint            dx;
        longint            dy;
        logic [31:0]       rounded;
        logic [15:0]       err;
        logic [16:0]       mag;
        longint unsigned   scaled;
        logic [3:0]        tenths;
        longint unsigned   decay;
        longint unsigned   d2;
        longint unsigned   lim;
        longint unsigned   ratio;
        longint unsigned   fac;
        longint unsigned   outer;
        longint unsigned   inner;
        bit                positive;
        speeds_t           s;
        dx = longint'(tx) - longint'(rx);
        dy = longint'(ty) - longint'(ry);
        rounded  = bearing_turns(dx, dy) + 32'h0000_8000;
        err      = rounded[31:16] - hd;
        positive = (err != 0) && !err[15];
        mag      = err[15] ? (17'h10000 - {1'b0, err}) : {1'b0, err};
        scaled   = longint'(mag) * 360;

        if (scaled > (64'd100 << 16))      tenths = ddgp_pkg::INNER_SPIN;
        else if (scaled > (64'd90 << 16))  tenths = ddgp_pkg::INNER_SHARP;
        else if (scaled > (64'd50 << 16))  tenths = ddgp_pkg::INNER_MEDIUM;
        else if (scaled > (64'd20 << 16))  tenths = ddgp_pkg::INNER_GENTLE;
        else if (scaled >= (64'd1 << 16))  tenths = ddgp_pkg::INNER_TRIM;
        else                               tenths = ddgp_pkg::INNER_STRAIGHT;

        decay = (decay_px == 0) ? 1 : decay_px;
        d2    = longint'(dx * dx) + longint'(dy * dy);
        lim   = 16 * decay;
        if (d2 >= lim * lim)
            ratio = 64'd16 << 16;
        else
        begin
            ratio = (root_floor(d2 << 16) << 8) / decay;
            if (ratio > (64'd16 << 16))
                ratio = 64'd16 << 16;
        end
        fac   = approach_q32(ratio);
        outer = (longint'(top_speed) * fac + (64'd1 << 31)) >> 32;
        inner = (longint'(top_speed) * tenths * fac + (64'd5 << 32)) / (64'd10 << 32);
        if (outer > 16'hFFFF) outer = 16'hFFFF;
        if (inner > 16'hFFFF) inner = 16'hFFFF;

        // positive error: target to the left, so the right wheel is inner
        if (positive)
        begin
            s.left  = outer[15:0];
            s.right = inner[15:0];
        end
        else
        begin
            s.left  = inner[15:0];
            s.right = outer[15:0];
        end
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: done is a one-cycle strobe that cannot be held off
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            speeds_t want;
            if (pending_speeds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: left %0d right %0d", left_speed, right_speed);
            end
            else
            begin
                want = pending_speeds.pop_front();
                words_checked++;
                if (left_speed !== want.left || right_speed !== want.right)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: left %0d (want %0d) right %0d (want %0d)",
                                 left_speed, want.left, right_speed, want.right);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("timeout with %0d words outstanding", pending_speeds.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Shared tasks
    // ------------------------------------------------------------------------

    // gap length: mostly none or short, now and then long
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 19);
        if (no_gaps || pick < 11)
            return 0;
        if (pick < 18)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // send one request word and record its expected speeds once accepted
    task automatic send_request(input logic signed [15:0] tx, input logic signed [15:0] ty,
                                input logic signed [15:0] rx, input logic signed [15:0] ry,
                                input logic signed [15:0] hd);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        target_x      <= tx;
        target_y      <= ty;
        robot_x       <= rx;
        robot_y       <= ry;
        robot_heading <= hd;
        do
            @(posedge clk);
        while (busy);
        pending_speeds.push_back(wheel_speeds(tx, ty, rx, ry, hd));
        requests_sent++;
    endtask

    // hold the sender until every expected word has arrived
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_speeds.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(posedge clk);
        wr_en    <= 1'b0;
        if (idx == ddgp_pkg::REG_MAX_SPEED)
            top_speed = value;
        else
            decay_px = value;
        @(posedge clk);
    endtask

    task automatic send_random(input int count, input bit near);
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        for (int i = 0; i < count; i++)
        begin
            rx = 16'($urandom);
            ry = 16'($urandom);
            // near targets lie within 300 of the robot on each axis
            if (near)
                send_request(rx + $signed(16'($urandom_range(0, 600)) - 16'sd300),
                             ry + $signed(16'($urandom_range(0, 600)) - 16'sd300),
                             rx, ry, 16'($urandom));
            else
                send_request(16'($urandom), 16'($urandom), rx, ry, 16'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // every error band on both sides, robot on target, coordinate extremes
    task automatic test_directed();
        int degs[8] = '{0, 1, 10, 30, 70, 95, 150, 180};
        int units;
        send_request(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_request(16'sd123, -16'sd77, 16'sd123, -16'sd77, 16'sd9000);
        for (int i = 0; i < 8; i++)
        begin
            units = (degs[i] * 65536 + 180) / 360;
            // target straight ahead on +x, so the error is minus the heading
            send_request(16'sd1000, 16'sd0, 16'sd0, 16'sd0, 16'(units));
            send_request(16'sd1000, 16'sd0, 16'sd0, 16'sd0, 16'(-units));
        end
        send_request(16'sd40, 16'sd0, 16'sd0, 16'sd0, 16'sd91);
        send_request(16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000, -16'sh8000);
        send_request(-16'sh8000, 16'sh7FFF, 16'sh7FFF, -16'sh8000, 16'sh7FFF);
        send_request(-16'sd5, 16'sd0, 16'sd0, 16'sd0, -16'sh8000);
        send_request(16'sd0, 16'sd3, 16'sd0, 16'sd0, 16'sd16384);
        send_request(16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd0);
        drain();
    endtask

    // register extremes, including decay of zero, each with a burst of requests
    task automatic test_settings();
        logic [15:0] speeds[5] = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd256, 16'd7680};
        logic [15:0] decays[5] = '{16'd1, 16'hFFFF, 16'd0, 16'd300, 16'd20};
        for (int k = 0; k < 5; k++)
        begin
            write_reg(ddgp_pkg::REG_MAX_SPEED, speeds[k]);
            write_reg(ddgp_pkg::REG_DECAY_DISTANCE, decays[k]);
            no_gaps = (k == 1);
            send_random(12, 1'b1);
            send_random(8, 1'b0);
            drain();
        end
        no_gaps = 1'b0;
    endtask

    // bulk random traffic, most of it near the robot, under random registers
    task automatic test_random();
        for (int phase = 0; phase < 5; phase++)
        begin
            write_reg(ddgp_pkg::REG_MAX_SPEED, 16'($urandom));
            write_reg(ddgp_pkg::REG_DECAY_DISTANCE, 16'($urandom_range(1, 2000)));
            no_gaps = (phase == 2);
            send_random(N_RANDOM / 5 * 2 / 3, 1'b1);
            send_random(N_RANDOM / 5 / 3, 1'b0);
            drain();
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        target_x      = '0;
        target_y      = '0;
        robot_x       = '0;
        robot_y       = '0;
        robot_heading = '0;
        wr_en         = 1'b0;
        wr_index      = ddgp_pkg::REG_MAX_SPEED;
        wr_data       = '0;
        top_speed     = 16'd7680;
        decay_px      = 16'd20;
        mismatches    = 0;
        words_checked = 0;
        requests_sent = 0;
        cycle_count   = 0;
        no_gaps       = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_settings();
        test_random();

        $display("covered %0d requests and %0d speed words across eleven register phases",
                 requests_sent, words_checked);
        $display("error bands on both sides, robot on target, zero decay, far targets");
        if (mismatches == 0 && pending_speeds.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
